// File: rtl/core/clm_pkg.sv
`default_nettype none
package clm_pkg;

    // widths fixed by the transaction fields
    localparam int SEED_W  = 64;
    localparam int COUNT_W = 33;
    localparam int TOTAL_W = 32;
    localparam int MEMO_W  = TOTAL_W + 1;   // known flag + total
    localparam int LIMIT_W = 32;
    localparam int LOG2_W  = 5;

    // defaults for the top-level parameters
    localparam int MEMO_ADDR_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF     = 128;

    // register reset values and limits
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 32'd100000000;
    localparam logic [LOG2_W-1:0]  MEMO_LOG2_RST  = 5'd16;
    localparam logic [COUNT_W-1:0] STORE_LIMIT    = 33'd2147483647;

    // configuration register indexes
    localparam logic REG_STEP_LIMIT = 1'b0;
    localparam logic REG_MEMO_LOG2  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ONE   = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic [SEED_W-1:0] seed_high;
        logic [SEED_W-1:0] seed_low;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic [1:0]         status;
        logic               memo_used;
        logic [SEED_W-1:0]  peak_high;
        logic [SEED_W-1:0]  peak_low;
    } t_out;

    // memo port control
    typedef struct packed {
        logic rd;
        logic wr;
    } t_memo_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_LOOK,
        S_STRIP,
        S_DONE
    } t_state;

    // trailing zeros of a byte, 8 when the byte is zero
    function automatic logic [3:0] f_ctz8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/clm_memo.sv
`default_nettype none
module clm_memo #(
    parameter int MEMO_ADDR_BITS = clm_pkg::MEMO_ADDR_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  clm_pkg::t_memo_ctl           i_ctl,
    input  wire [MEMO_ADDR_BITS-1:0]     i_addr,
    input  wire [clm_pkg::MEMO_W-1:0]    i_wdata,
    output logic [clm_pkg::MEMO_W-1:0]   o_rdata,
    output logic                         o_busy
);

    localparam int DEPTH = 1 << MEMO_ADDR_BITS;

    logic [clm_pkg::MEMO_W-1:0] r_mem [DEPTH];
    logic [MEMO_ADDR_BITS-1:0]  r_clr;
    logic                       r_clearing;
    logic [MEMO_ADDR_BITS-1:0]  w_addr;
    logic [clm_pkg::MEMO_W-1:0] w_data;
    logic                       w_en;

    // clearing sweep after reset: every entry unknown, entry one known at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (&r_clr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clearing) begin
            w_en   = 1'b1;
            w_addr = r_clr;
            w_data = (r_clr == MEMO_ADDR_BITS'(1)) ? {1'b1, {clm_pkg::TOTAL_W{1'b0}}} : '0;
        end else begin
            w_en   = i_ctl.wr;
            w_addr = i_addr;
            w_data = i_wdata;
        end
    end

    // single port RAM, registered read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_ctl.rd) begin
            o_rdata <= r_mem[i_addr];
        end
    end

    assign o_busy = r_clearing;

endmodule
`default_nettype wire

// File: rtl/core/clm_core.sv
`default_nettype none
module clm_core #(
    parameter int MEMO_ADDR_BITS = clm_pkg::MEMO_ADDR_BITS_DEF,
    parameter int VALUE_BITS     = clm_pkg::VALUE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [VALUE_BITS-1:0]           i_seed,
    input  wire [clm_pkg::LIMIT_W-1:0]     i_limit,
    input  wire [clm_pkg::LOG2_W-1:0]      i_lg,
    input  wire [clm_pkg::MEMO_W-1:0]      i_mem_rdata,
    output clm_pkg::t_memo_ctl             o_mem_ctl,
    output logic [MEMO_ADDR_BITS-1:0]      o_mem_addr,
    output logic [clm_pkg::MEMO_W-1:0]     o_mem_wdata,
    output logic                           o_idle,
    output logic                           o_done,
    input  wire                            i_take,
    output clm_pkg::t_out                  o_res
);

    localparam int CW = clm_pkg::COUNT_W;

    clm_pkg::t_state           r_state, n_state;
    logic [VALUE_BITS-1:0]     r_v, n_v;
    logic [VALUE_BITS-1:0]     r_peak, n_peak;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [CW-1:0]             r_base, n_base;
    logic [MEMO_ADDR_BITS-1:0] r_idx, n_idx;
    logic                      r_memo, n_memo;
    logic                      r_looked, n_looked;
    logic [1:0]                r_status, n_status;
    logic                      r_used, n_used;

    logic [clm_pkg::LOG2_W-1:0] lg_c;
    logic                       v_one, v_small, v_odd, ovf, over_lim, rd_known;
    logic [VALUE_BITS+1:0]      tri_v;
    logic [3:0]                 sh;
    logic [CW-1:0]              rd_tot, tot_hit, tot_one;

    // value tests
    assign lg_c  = (i_lg > clm_pkg::LOG2_W'(MEMO_ADDR_BITS))
                   ? clm_pkg::LOG2_W'(MEMO_ADDR_BITS) : i_lg;
    assign v_one = (r_v == VALUE_BITS'(1));
    assign v_odd = r_v[0];

    always_comb begin
        v_small = 1'b1;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if ((i >= int'(lg_c)) && r_v[i]) begin
                v_small = 1'b0;
            end
        end
    end

    // 3n+1 and strip of up to eight twos per cycle
    assign tri_v    = {2'b00, r_v} + {1'b0, r_v, 1'b0} + (VALUE_BITS+2)'(1);
    assign ovf      = (tri_v[VALUE_BITS+1:VALUE_BITS] != 2'b00);
    assign sh       = clm_pkg::f_ctz8(r_v[7:0]);
    assign over_lim = (r_cnt > {1'b0, i_limit});

    // memo totals
    assign rd_known = i_mem_rdata[clm_pkg::TOTAL_W];
    assign rd_tot   = {1'b0, i_mem_rdata[clm_pkg::TOTAL_W-1:0]};
    assign tot_hit  = r_cnt - r_base + rd_tot;
    assign tot_one  = r_cnt - r_base;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_seed == '0) ? clm_pkg::S_DONE : clm_pkg::S_STEP;
                end
            end
            clm_pkg::S_STEP: begin
                if (v_one) begin
                    n_state = clm_pkg::S_DONE;
                end else if (v_small && !r_looked) begin
                    n_state = clm_pkg::S_LOOK;
                end else if (v_odd && ovf) begin
                    n_state = clm_pkg::S_DONE;
                end else begin
                    n_state = clm_pkg::S_STRIP;
                end
            end
            clm_pkg::S_LOOK: begin
                n_state = rd_known ? clm_pkg::S_DONE : clm_pkg::S_STEP;
            end
            clm_pkg::S_STRIP: begin
                if (v_odd) begin
                    n_state = over_lim ? clm_pkg::S_DONE : clm_pkg::S_STEP;
                end
            end
            clm_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = clm_pkg::S_IDLE;
                end
            end
            default: n_state = clm_pkg::S_IDLE;
        endcase
    end

    // datapath and memo port
    always_comb begin
        n_v         = r_v;
        n_peak      = r_peak;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_idx       = r_idx;
        n_memo      = r_memo;
        n_looked    = r_looked;
        n_status    = r_status;
        n_used      = r_used;
        o_mem_ctl   = '0;
        o_mem_addr  = r_v[MEMO_ADDR_BITS-1:0];
        o_mem_wdata = '0;
        case (r_state)
            clm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_v      = i_seed;
                    n_peak   = i_seed;
                    n_cnt    = '0;
                    n_memo   = 1'b0;
                    n_looked = 1'b0;
                    n_used   = 1'b0;
                    n_status = (i_seed == '0) ? clm_pkg::ST_ZERO : clm_pkg::ST_ONE;
                end
            end
            clm_pkg::S_STEP: begin
                if (v_one) begin
                    // memo walk ended at one: store its own total
                    if (r_memo) begin
                        n_used        = 1'b1;
                        o_mem_addr    = r_idx;
                        o_mem_wdata   = {1'b1, tot_one[clm_pkg::TOTAL_W-1:0]};
                        o_mem_ctl.wr  = (tot_one < clm_pkg::STORE_LIMIT);
                    end
                end else if (v_small && !r_looked) begin
                    o_mem_ctl.rd = 1'b1;
                    n_looked     = 1'b1;
                end else begin
                    n_looked = 1'b0;
                    if (v_odd) begin
                        if (ovf) begin
                            n_status = clm_pkg::ST_OVF;
                            n_used   = 1'b0;
                        end else begin
                            n_v   = tri_v[VALUE_BITS-1:0];
                            n_cnt = r_cnt + CW'(1);
                        end
                    end
                end
            end
            clm_pkg::S_LOOK: begin
                if (rd_known) begin
                    n_cnt  = r_cnt + rd_tot;
                    n_used = 1'b1;
                    if (r_memo) begin
                        o_mem_addr   = r_idx;
                        o_mem_wdata  = {1'b1, tot_hit[clm_pkg::TOTAL_W-1:0]};
                        o_mem_ctl.wr = (tot_hit < clm_pkg::STORE_LIMIT);
                    end
                end else if (!r_memo) begin
                    // first unknown small value: start the memo walk
                    n_memo = 1'b1;
                    n_base = r_cnt;
                    n_idx  = r_v[MEMO_ADDR_BITS-1:0];
                end
            end
            clm_pkg::S_STRIP: begin
                if (!v_odd) begin
                    n_v   = r_v >> sh;
                    n_cnt = r_cnt + CW'(sh);
                end else begin
                    // step complete: peak and limit
                    if (r_v > r_peak) begin
                        n_peak = r_v;
                    end
                    if (over_lim) begin
                        n_status = clm_pkg::ST_LIMIT;
                        n_used   = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_v      <= n_v;
        r_peak   <= n_peak;
        r_cnt    <= n_cnt;
        r_base   <= n_base;
        r_idx    <= n_idx;
        r_memo   <= n_memo;
        r_looked <= n_looked;
        r_status <= n_status;
        r_used   <= n_used;
    end

    assign o_idle = (r_state == clm_pkg::S_IDLE);
    assign o_done = (r_state == clm_pkg::S_DONE);

    // result
    always_comb begin
        logic [2*clm_pkg::SEED_W-1:0] pk;
        pk               = (2*clm_pkg::SEED_W)'(r_peak);
        o_res.step_count = r_cnt;
        o_res.status     = r_status;
        o_res.memo_used  = r_used;
        o_res.peak_high  = pk[2*clm_pkg::SEED_W-1:clm_pkg::SEED_W];
        o_res.peak_low   = pk[clm_pkg::SEED_W-1:0];
    end

endmodule
`default_nettype wire

// File: rtl/core/collatz_step_counter_memo.sv
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | i_in  (clm_pkg::t_in)
// out      | output    | o_out_valid / i_out_stall  | o_out (clm_pkg::t_out)
// cfg      | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One seed at a time: the seed is taken, walked, and its result handed on.
// Each shortcut step passes S_STEP and then S_STRIP, which strips up to eight twos per pass;
// each memo lookup issues a read on the single memo port in S_STEP and uses it in S_LOOK.
// After reset a clearing pass writes every memo entry; no seed is taken while it runs.
// A finished result sits in the output register while the next seed is walked.
`default_nettype none
module collatz_step_counter_memo #(
    parameter int MEMO_ADDR_BITS = clm_pkg::MEMO_ADDR_BITS_DEF,
    parameter int VALUE_BITS     = clm_pkg::VALUE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  clm_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output clm_pkg::t_out                o_out,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [clm_pkg::LIMIT_W-1:0]   i_cfg_data
);

    logic [clm_pkg::LIMIT_W-1:0] r_limit;
    logic [clm_pkg::LOG2_W-1:0]  r_lg;
    logic                        r_out_valid;
    clm_pkg::t_out               r_out;

    clm_pkg::t_memo_ctl          mem_ctl;
    logic [MEMO_ADDR_BITS-1:0]   mem_addr;
    logic [clm_pkg::MEMO_W-1:0]  mem_wdata, mem_rdata;
    logic                        mem_busy, core_idle, core_done, take, start;
    clm_pkg::t_out               core_res;
    logic [2*clm_pkg::SEED_W-1:0] seed_all;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= clm_pkg::STEP_LIMIT_RST;
            r_lg    <= clm_pkg::MEMO_LOG2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clm_pkg::REG_STEP_LIMIT: r_limit <= i_cfg_data;
                clm_pkg::REG_MEMO_LOG2:  r_lg    <= i_cfg_data[clm_pkg::LOG2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = !core_idle || mem_busy;
    assign start      = i_in_valid && !o_in_stall;
    assign seed_all   = {i_in.seed_high, i_in.seed_low};
    assign take       = !r_out_valid || !i_out_stall;

    clm_memo #(
        .MEMO_ADDR_BITS(MEMO_ADDR_BITS)
    ) u_memo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    clm_core #(
        .MEMO_ADDR_BITS(MEMO_ADDR_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_seed      (seed_all[VALUE_BITS-1:0]),
        .i_limit     (r_limit),
        .i_lg        (r_lg),
        .i_mem_rdata (mem_rdata),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .o_idle      (core_idle),
        .o_done      (core_done),
        .i_take      (take),
        .o_res       (core_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= core_done;
        end
        if (take && core_done) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    a_memo_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.memo_used |-> o_out.status == clm_pkg::ST_ONE)
        else $error("memo_used on a result that did not reach one");

    a_zero_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == clm_pkg::ST_ZERO |->
        o_out.step_count == '0 && o_out.peak_high == '0 && o_out.peak_low == '0)
        else $error("zero seed result carries nonzero fields");

    a_busy_after : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_in_stall)
        else $error("seed taken while a walk is in progress");

endmodule
`default_nettype wire

// File: tb/sv/tb_collatz_step_counter_memo.sv
`timescale 1ns / 1ps
module tb_collatz_step_counter_memo;

    localparam int MEMO_DEPTH = 1 << clm_pkg::MEMO_ADDR_BITS_DEF;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    clm_pkg::t_in                  seed_in;
    logic                          out_valid;
    logic                          out_stall;
    clm_pkg::t_out                 result_out;
    logic                          cfg_we;
    logic                          cfg_idx;
    logic [clm_pkg::LIMIT_W-1:0]   cfg_data;

    collatz_step_counter_memo DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (seed_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (result_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // mirror of the block's registers and memo table
    logic [clm_pkg::LIMIT_W-1:0] step_limit_reg;
    logic [clm_pkg::LOG2_W-1:0]  memo_log2_reg;
    bit                          memo_known [MEMO_DEPTH];
    logic [31:0]                 memo_total [MEMO_DEPTH];

    clm_pkg::t_out expected_results [$];
    int   error_count;
    int   checked_count;
    int   status_seen [4];
    int   memo_hits_seen;
    int   burst_left;
    int   hold_left;
    int   stall_mode;
    int   stall_mode_left;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic int trailing_zeros(input logic [127:0] v);
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                return i;
            end
        end
        return 128;
    endfunction

    // one shortcut step on a nonzero value, 0 on overflow
    function automatic bit collatz_step(inout logic [127:0] v, inout logic [63:0] n);
        int           z;
        logic [129:0] t;
        z = trailing_zeros(v);
        if (z != 0) begin
            v = v >> z;
            n = n + z;
            return 1'b1;
        end
        t = {2'b00, v} * 130'd3 + 130'd1;
        if (t[129:128] != 2'b00) begin
            return 1'b0;
        end
        z = trailing_zeros(t[127:0]);
        v = t[127:0] >> z;
        n = n + 1 + z;
        return 1'b1;
    endfunction

    function automatic bit below_memo_limit(input logic [127:0] v);
        int lg;
        lg = (memo_log2_reg > clm_pkg::MEMO_ADDR_BITS_DEF) ? clm_pkg::MEMO_ADDR_BITS_DEF
             : int'(memo_log2_reg);
        return v < (128'd1 << lg);
    endfunction

    function automatic clm_pkg::t_out predict_stopping_time(input logic [127:0] seed);
        clm_pkg::t_out r;
        logic [127:0] v;
        logic [127:0] m;
        logic [127:0] peak;
        logic [63:0]  steps;
        logic [63:0]  add;
        logic [63:0]  total;
        logic [1:0]   st;
        bit           used;
        bit           stop;
        logic [15:0]  idx;
        v     = seed;
        peak  = seed;
        steps = '0;
        st    = clm_pkg::ST_ONE;
        used  = 1'b0;
        if (seed == '0) begin
            st = clm_pkg::ST_ZERO;
        end else begin
            while (v != 128'd1) begin
                if (below_memo_limit(v)) begin
                    idx = v[15:0];
                    if (memo_known[idx]) begin
                        steps = steps + memo_total[idx];
                        used  = 1'b1;
                        break;
                    end
                    // miss: walk on to a known entry or to one
                    m    = v;
                    add  = '0;
                    stop = 1'b0;
                    while (m != 128'd1 && !(below_memo_limit(m) && memo_known[m[15:0]])) begin
                        if (!collatz_step(m, add)) begin
                            steps = steps + add;
                            st    = clm_pkg::ST_OVF;
                            stop  = 1'b1;
                            break;
                        end
                        if (m > peak) begin
                            peak = m;
                        end
                        if (steps + add > step_limit_reg) begin
                            steps = steps + add;
                            st    = clm_pkg::ST_LIMIT;
                            stop  = 1'b1;
                            break;
                        end
                    end
                    if (stop) begin
                        break;
                    end
                    total = add + ((m == 128'd1) ? 64'd0 : 64'(memo_total[m[15:0]]));
                    if (total < clm_pkg::STORE_LIMIT) begin
                        memo_total[idx] = total[31:0];
                        memo_known[idx] = 1'b1;
                    end
                    steps = steps + total;
                    used  = 1'b1;
                    break;
                end
                if (!collatz_step(v, steps)) begin
                    st = clm_pkg::ST_OVF;
                    break;
                end
                if (v > peak) begin
                    peak = v;
                end
                if (steps > step_limit_reg) begin
                    st = clm_pkg::ST_LIMIT;
                    break;
                end
            end
        end
        r.step_count = (steps > 64'h1_FFFF_FFFF) ? {clm_pkg::COUNT_W{1'b1}}
                       : steps[clm_pkg::COUNT_W-1:0];
        r.status     = st;
        r.memo_used  = used;
        r.peak_high  = peak[127:64];
        r.peak_low   = peak[63:0];
        return r;
    endfunction

    // ---------------- result checker ----------------
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("MISMATCH result %0d %s: got %h expected %h", checked_count, field, got, want);
    endtask

    always @(posedge clk) begin
        clm_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(result_out.step_count), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (result_out.step_count !== want.step_count)
                    report_mismatch("step_count", 64'(result_out.step_count), 64'(want.step_count));
                if (result_out.status !== want.status)
                    report_mismatch("status", 64'(result_out.status), 64'(want.status));
                if (result_out.memo_used !== want.memo_used)
                    report_mismatch("memo_used", 64'(result_out.memo_used), 64'(want.memo_used));
                if (result_out.peak_high !== want.peak_high)
                    report_mismatch("peak_high", result_out.peak_high, want.peak_high);
                if (result_out.peak_low !== want.peak_low)
                    report_mismatch("peak_low", result_out.peak_low, want.peak_low);
                status_seen[want.status]++;
                if (want.memo_used) begin
                    memo_hits_seen++;
                end
                checked_count++;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      <= $urandom_range(0, 2);
                stall_mode_left <= $urandom_range(50, 400);
            end else begin
                stall_mode_left <= stall_mode_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // ---------------- sender side ----------------
    task automatic send_seed(input logic [127:0] seed);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid          <= 1'b1;
        seed_in.seed_high <= seed[127:64];
        seed_in.seed_low  <= seed[63:0];
        do begin
            @(posedge clk);
        end while (in_stall);
        expected_results.push_back(predict_stopping_time(seed));
    endtask

    // wait until every expected result has come, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [clm_pkg::LIMIT_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == clm_pkg::REG_STEP_LIMIT) begin
            step_limit_reg = value;
        end else begin
            memo_log2_reg = value[clm_pkg::LOG2_W-1:0];
        end
        @(posedge clk);
    endtask

    // random seed, mostly narrow so paths stay short, now and then full width
    function automatic logic [127:0] random_seed();
        logic [127:0] v;
        int           w;
        v = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 19) == 0) begin
            w = 128;
        end else begin
            w = $urandom_range(1, 40);
        end
        if (w < 128) begin
            v = v & ((128'd1 << w) - 1);
        end
        return v;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed_seeds();
        send_seed(128'd0);
        send_seed(128'd1);
        send_seed(128'd2);
        send_seed(128'd3);
        send_seed(128'd27);
        send_seed(128'd27);                               // memo hit
        send_seed(128'd65535);
        send_seed(128'd65536);
        send_seed({128{1'b1}});                           // overflow at once
        send_seed(128'h5555_5555_5555_5555_5555_5555_5555_5555); // 3n+1 just past the top
        send_seed(128'h5555_5555_5555_5555_5555_5555_5555_5553); // just fits
        send_seed(128'h8000_0000_0000_0000_0000_0000_0000_0000);
        send_seed(128'h0000_0000_0000_0001_0000_0000_0000_0000);
        send_seed(128'hFFFF_FFFF_FFFF_FFFF_0000_0000_0000_0000);
        send_seed(128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF);
        send_seed(128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAB);
        send_seed(128'd837799);
        send_seed(128'd97);
        drain_results();
    endtask

    task automatic test_step_limit();
        write_register(clm_pkg::REG_STEP_LIMIT, 32'd0);
        send_seed(128'd27);
        send_seed(128'd7);
        send_seed(128'd1);
        write_register(clm_pkg::REG_STEP_LIMIT, 32'd5);
        send_seed(128'd871);
        send_seed(128'd3);
        send_seed(128'h1_0000_0000_0000_0001);
        write_register(clm_pkg::REG_STEP_LIMIT, 32'd60);
        for (int i = 0; i < 12; i++) begin
            send_seed(random_seed());
        end
        write_register(clm_pkg::REG_STEP_LIMIT, 32'hFFFF_FFFF);
        send_seed(128'd703);
        drain_results();
    endtask

    task automatic test_memo_limit();
        write_register(clm_pkg::REG_MEMO_LOG2, 32'd0);    // memo never used
        send_seed(128'd27);
        send_seed(128'd6171);
        write_register(clm_pkg::REG_MEMO_LOG2, 32'd1);
        send_seed(128'd6171);
        send_seed(128'd77031);
        write_register(clm_pkg::REG_MEMO_LOG2, 32'd31);   // clamped to the table size
        send_seed(128'd77031);
        send_seed(128'd60000);
        write_register(clm_pkg::REG_MEMO_LOG2, 32'h1F);
        write_register(clm_pkg::REG_MEMO_LOG2, 32'd8);
        send_seed(128'd231);
        send_seed(128'd255);
        drain_results();
    endtask

    task automatic test_random_seeds(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 149) begin
                if ($urandom_range(0, 3) == 0) begin
                    write_register(clm_pkg::REG_STEP_LIMIT, $urandom_range(0, 400));
                end else begin
                    write_register(clm_pkg::REG_STEP_LIMIT, $urandom_range(1000, 32'hFFFF_FFFF));
                end
                write_register(clm_pkg::REG_MEMO_LOG2, $urandom_range(0, 31));
            end
            send_seed(random_seed());
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        hold_left = 3000;
        for (int i = 0; i < 12; i++) begin
            send_seed(random_seed());
        end
        drain_results();
    endtask

    // ---------------- run ----------------
    initial begin
        for (int i = 0; i < MEMO_DEPTH; i++) begin
            memo_known[i] = 1'b0;
            memo_total[i] = '0;
        end
        memo_known[1]   = 1'b1;
        step_limit_reg  = clm_pkg::STEP_LIMIT_RST;
        memo_log2_reg   = clm_pkg::MEMO_LOG2_RST;
        error_count     = 0;
        checked_count   = 0;
        memo_hits_seen  = 0;
        burst_left      = 0;
        hold_left       = 0;
        stall_mode      = 0;
        stall_mode_left = 0;
        for (int i = 0; i < 4; i++) begin
            status_seen[i] = 0;
        end
        rst_n    = 1'b0;
        in_valid = 1'b0;
        seed_in  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = clm_pkg::REG_STEP_LIMIT;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_seeds();
        test_step_limit();
        test_memo_limit();
        test_output_backpressure();
        test_random_seeds(1650);
        write_register(clm_pkg::REG_STEP_LIMIT, clm_pkg::STEP_LIMIT_RST);
        write_register(clm_pkg::REG_MEMO_LOG2, 32'(clm_pkg::MEMO_LOG2_RST));
        test_random_seeds(40);
        repeat (50) @(posedge clk);

        $display("checked %0d results: %0d reached one, %0d overflow, %0d limit, %0d zero",
                 checked_count, status_seen[clm_pkg::ST_ONE], status_seen[clm_pkg::ST_OVF],
                 status_seen[clm_pkg::ST_LIMIT], status_seen[clm_pkg::ST_ZERO]);
        $display("%0d results ended through the memo table", memo_hits_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_collatz_step_counter_memo: clean");
        end else begin
            $display("tb_collatz_step_counter_memo: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb_collatz_step_counter_memo: errors");
        $finish;
    end

endmodule

// File: collatz_step_counter_memo.f
rtl/core/clm_pkg.sv
rtl/core/clm_memo.sv
rtl/core/clm_core.sv
rtl/core/collatz_step_counter_memo.sv
tb/sv/tb_collatz_step_counter_memo.sv
